/* rtl/core/tcw_pkg.sv */
// shared types and codes of the text console writer
package tcw_pkg;

   // request action codes
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // control characters and fixed cell values
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BLANK     = 8'h20;
   localparam int         TAB_STEP     = 4;

   // register indexes of the csr port
   localparam logic REG_BACKGROUND = 1'b0;
   localparam logic REG_FOREGROUND = 1'b1;

   // what a put request does to the screen store
   typedef struct packed {
      logic write_cell;
      logic scroll;
   } put_ctl_type;

endpackage

/* rtl/core/text_console_writer_unit.sv */
// text console writer: screen store, cursor, put / clear / read requests
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------------
//   req     | in        | tuser: action; tdata: char_code, read_row, read_col
//   rsp     | out       | tdata: cursor_row, cursor_col, cell_char, cell_attr
//   csr     | in        | register index, write data (colors), write enable
//
// one request at a time; the screen store is a single-port-write memory, one
// cell written per cycle; a plain put writes its cell when it is accepted, a
// put that scrolls blanks one row in place and then writes the character (rows
// are addressed through a rotating top-row offset, nothing is copied)
// clear blanks every cell; after reset a zeroing pass over every cell runs with
// req_tready low; a stalled response holds the next request in its done state
module text_console_writer_unit #(
   parameter int SCREEN_ROWS = 25,
   parameter int SCREEN_COLS = 80
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // lowest bit up: char_code[7:0], read_row, read_col, zero fill to bytes
   input  logic [((8 + $clog2(SCREEN_ROWS+1) + $clog2(SCREEN_COLS+1) + 7) / 8) * 8 - 1:0]
                req_tdata,
   // lowest bit up: action[1:0]
   input  logic [1:0] req_tuser,
   // response channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // lowest bit up: cursor_row, cursor_col, cell_char[7:0], cell_attr[7:0], zero fill
   output logic [(($clog2(SCREEN_ROWS+1) + $clog2(SCREEN_COLS+1) + 16 + 7) / 8) * 8 - 1:0]
                rsp_tdata,
   // configuration port
   input  logic       csr_we,
   input  logic       csr_addr,
   input  logic [3:0] csr_wdata
);
   import tcw_pkg::*;

   localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
   localparam int COL_W  = $clog2(SCREEN_COLS + 1);
   localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int REQ_W  = 8 + ROW_W + COL_W;
   localparam int REQ_DW = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W  = ROW_W + COL_W + 16;
   localparam int RSP_DW = ((RSP_W + 7) / 8) * 8;

   // sequencer states
   localparam logic [2:0] S_INIT = 3'd0;  // zeroing pass after reset
   localparam logic [2:0] S_IDLE = 3'd1;  // waiting for a request
   localparam logic [2:0] S_FILL = 3'd2;  // blanking a row or the whole screen
   localparam logic [2:0] S_CHAR = 3'd3;  // character write after a scroll
   localparam logic [2:0] S_DONE = 3'd4;  // response waiting for the output register

   // request fields
   logic [7:0]       req_char;
   logic [ROW_W-1:0] req_row;
   logic [COL_W-1:0] req_col;
   logic             req_fire;

   assign req_char = req_tdata[7:0];
   assign req_row  = req_tdata[8 +: ROW_W];
   assign req_col  = req_tdata[8 + ROW_W +: COL_W];

   // state registers
   logic [2:0]       state_ff, state_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] top_ff, top_in;           // physical row of logical row 0
   logic [3:0]       bg_ff, fg_ff;
   logic [AW-1:0]    fill_addr_ff, fill_addr_in;
   logic [AW-1:0]    fill_last_ff, fill_last_in;
   logic [15:0]      fill_data_ff, fill_data_in;
   logic             char_pend_ff, char_pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;
   logic [15:0]      pend_data_ff, pend_data_in;
   logic             rd_hit_ff, rd_hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // screen memory ports
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   rd_data_ff;
   logic [15:0]   screen_mem [DEPTH];

   // cursor unit
   logic [ROW_W-1:0] put_row_next, put_row;
   logic [COL_W-1:0] put_col_next, put_col;
   put_ctl_type      put_ctl;

   tcw_cursor #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .SCREEN_COLS (SCREEN_COLS)
   ) u_cursor (
      .row       (cur_row_ff),
      .col       (cur_col_ff),
      .char_code (req_char),
      .row_next  (put_row_next),
      .col_next  (put_col_next),
      .put_row   (put_row),
      .put_col   (put_col),
      .ctl       (put_ctl)
   );

   // current attribute and blank cell
   logic [7:0]  attr;
   logic [15:0] blank_cell;

   assign attr       = {bg_ff, fg_ff};
   assign blank_cell = {attr, CH_BLANK};

   // logical to physical rows through the top-row offset
   logic [ROW_W:0]   put_phys_sum, rd_phys_sum;
   logic [ROW_W-1:0] put_phys, rd_phys;
   logic [AW-1:0]    put_addr, rd_addr, top_base;
   logic             rd_in_range;

   assign put_phys_sum = {1'b0, put_row} + {1'b0, top_ff};
   assign put_phys     = (put_phys_sum >= (ROW_W+1)'(SCREEN_ROWS)) ?
                         ROW_W'(put_phys_sum - (ROW_W+1)'(SCREEN_ROWS)) :
                         put_phys_sum[ROW_W-1:0];
   assign rd_phys_sum  = {1'b0, req_row} + {1'b0, top_ff};
   assign rd_phys      = (rd_phys_sum >= (ROW_W+1)'(SCREEN_ROWS)) ?
                         ROW_W'(rd_phys_sum - (ROW_W+1)'(SCREEN_ROWS)) :
                         rd_phys_sum[ROW_W-1:0];
   assign put_addr     = AW'(put_phys) * AW'(SCREEN_COLS) + AW'(put_col);
   assign rd_addr      = AW'(rd_phys) * AW'(SCREEN_COLS) + AW'(req_col);
   // on a scroll the old top row becomes the bottom row
   assign top_base     = AW'(top_ff) * AW'(SCREEN_COLS);
   assign rd_in_range  = (req_row < ROW_W'(SCREEN_ROWS)) &&
                         (req_col < COL_W'(SCREEN_COLS));

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // sequencer and memory port selection
   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      fill_data_in = fill_data_ff;
      char_pend_in = char_pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = fill_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = rd_addr;

      unique case (state_ff)
         S_INIT, S_FILL: begin
            mem_we = 1'b1;
            if (fill_addr_ff == fill_last_ff) begin
               priority if (state_ff == S_INIT) begin
                  state_in = S_IDLE;
               end else if (char_pend_ff) begin
                  state_in = S_CHAR;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               fill_addr_in = fill_addr_ff + AW'(1);
            end
         end
         S_CHAR: begin
            mem_we       = 1'b1;
            mem_waddr    = pend_addr_ff;
            mem_wdata    = pend_data_ff;
            char_pend_in = 1'b0;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rd_hit_ff ? rd_data_ff : 16'h0000, cur_col_ff, cur_row_ff};
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               rd_hit_in = 1'b0;
               state_in  = S_DONE;
               unique case (req_tuser)
                  ACT_PUT: begin
                     cur_row_in = put_row_next;
                     cur_col_in = put_col_next;
                     if (put_ctl.write_cell && put_ctl.scroll) begin
                        // rotate the top row, blank the new bottom row, then write
                        top_in       = (top_ff == ROW_W'(SCREEN_ROWS - 1)) ?
                                       '0 : top_ff + ROW_W'(1);
                        fill_addr_in = top_base;
                        fill_last_in = top_base + AW'(SCREEN_COLS - 1);
                        fill_data_in = blank_cell;
                        char_pend_in = 1'b1;
                        pend_addr_in = top_base + AW'(put_col);
                        pend_data_in = {attr, req_char};
                        state_in     = S_FILL;
                     end else if (put_ctl.write_cell) begin
                        mem_we    = 1'b1;
                        mem_waddr = put_addr;
                        mem_wdata = {attr, req_char};
                     end
                  end
                  ACT_CLEAR: begin
                     cur_row_in   = '0;
                     cur_col_in   = '0;
                     top_in       = '0;
                     fill_addr_in = '0;
                     fill_last_in = AW'(DEPTH - 1);
                     fill_data_in = blank_cell;
                     char_pend_in = 1'b0;
                     state_in     = S_FILL;
                  end
                  ACT_READ: begin
                     mem_re    = rd_in_range;
                     rd_hit_in = rd_in_range;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         bg_ff        <= 4'h0;
         fg_ff        <= 4'hf;
         fill_addr_ff <= '0;
         fill_last_ff <= AW'(DEPTH - 1);
         fill_data_ff <= '0;
         char_pend_ff <= 1'b0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         fill_addr_ff <= fill_addr_in;
         fill_last_ff <= fill_last_in;
         fill_data_ff <= fill_data_in;
         char_pend_ff <= char_pend_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               REG_BACKGROUND: bg_ff <= csr_wdata;
               REG_FOREGROUND: fg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // screen memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'(rsp_data_ff);

`ifndef NO_ASSERTIONS
   // cursor row never passes the scroll-pending value
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      cur_row_ff <= ROW_W'(SCREEN_ROWS))
      else $error("cursor row out of range");

   // top-row offset stays a valid physical row
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff < ROW_W'(SCREEN_ROWS))
      else $error("top row offset out of range");

   // blanking sweep stays inside its span and the memory
   a_fill_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL || state_ff == S_INIT) |->
         (fill_addr_ff <= fill_last_ff) && (fill_last_ff <= AW'(DEPTH - 1)))
      else $error("fill address outside its span");

   // a pending character write only follows a scroll fill
   a_char_after_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHAR) |-> $past(state_ff) == S_FILL)
      else $error("character write without a preceding row fill");

   // no response during the zeroing pass after reset
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_valid_ff)
      else $error("response during reset zeroing pass");
`endif

endmodule

/* rtl/core/tcw_cursor.sv */
// cursor update of a put request: control characters, wrap and scroll decision
module tcw_cursor #(
   parameter int SCREEN_ROWS = 25,
   parameter int SCREEN_COLS = 80,
   parameter int ROW_W       = $clog2(SCREEN_ROWS + 1),
   parameter int COL_W       = $clog2(SCREEN_COLS + 1)
) (
   input  logic [ROW_W-1:0]     row,
   input  logic [COL_W-1:0]     col,
   input  logic [7:0]           char_code,
   output logic [ROW_W-1:0]     row_next,
   output logic [COL_W-1:0]     col_next,
   output logic [ROW_W-1:0]     put_row,
   output logic [COL_W-1:0]     put_col,
   output tcw_pkg::put_ctl_type ctl
);
   import tcw_pkg::*;

   logic [ROW_W-1:0] row_adv;
   logic [COL_W:0]   tab_sum;
   logic             wrap;
   logic [ROW_W-1:0] wrap_row;
   logic [COL_W-1:0] wrap_col;

   // row advance saturates one past the last row
   assign row_adv  = (row < ROW_W'(SCREEN_ROWS)) ? row + ROW_W'(1) : row;
   assign tab_sum  = {1'b0, col} + (COL_W+1)'(TAB_STEP);
   assign wrap     = (col >= COL_W'(SCREEN_COLS));
   assign wrap_row = wrap ? row_adv : row;
   assign wrap_col = wrap ? '0 : col;

   always_comb begin
      row_next       = row;
      col_next       = col;
      put_row        = wrap_row;
      put_col        = wrap_col;
      ctl.write_cell = 1'b0;
      ctl.scroll     = 1'b0;
      priority if (char_code == CH_NEWLINE) begin
         row_next = row_adv;
         col_next = '0;
      end else if (char_code == CH_TAB) begin
         col_next = (tab_sum > (COL_W+1)'(SCREEN_COLS)) ?
                    COL_W'(SCREEN_COLS) : tab_sum[COL_W-1:0];
      end else if (char_code == CH_BACKSPACE) begin
         col_next = (col != '0) ? col - COL_W'(1) : col;
      end else begin
         ctl.write_cell = 1'b1;
         if (wrap_row >= ROW_W'(SCREEN_ROWS)) begin
            ctl.scroll = 1'b1;
            put_row    = ROW_W'(SCREEN_ROWS - 1);
         end
         row_next = put_row;
         col_next = wrap_col + COL_W'(1);
      end
   end

endmodule

/* tb/sv/tb_top.sv */
// testbench of the text console writer: directed table, then random text checked by a predictor
`timescale 1ns / 100ps

module tb_top;
   import tcw_pkg::*;

   localparam int SCREEN_ROWS = 25;
   localparam int SCREEN_COLS = 80;
   localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
   localparam int COL_W = $clog2(SCREEN_COLS + 1);
   localparam int REQ_W = ((8 + ROW_W + COL_W + 7) / 8) * 8;
   localparam int RSP_W = ((ROW_W + COL_W + 16 + 7) / 8) * 8;

   // the fourth action code has no meaning; the block must leave everything alone
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 415;
   localparam int SETTLE_CYCLES   = 100;        // longer than a scrolling put
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int MAX_REPORTS     = 10;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [7:0]       char_code;
      logic [ROW_W-1:0] read_row;
      logic [COL_W-1:0] read_col;
   } request_type;

   typedef struct packed {
      logic [ROW_W-1:0] cursor_row;
      logic [COL_W-1:0] cursor_col;
      logic [7:0]       cell_char;
      logic [7:0]       cell_attr;
   } response_type;

   // one line of the directed table: a request, how often to send it, and
   // a hand-written response where it is obvious
   typedef struct packed {
      request_type  req;
      logic [7:0]   repeat_count;
      logic         typed;
      response_type want;
   } directed_row_type;

   localparam response_type NO_RSP = '0;
   localparam int DIRECTED_ROWS = 26;

   logic clock = 1'b0;
   logic reset;

   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic             csr_addr;
   logic [3:0]       csr_wdata;

   // shadow copy of the console: screen cells, cursor and colors
   logic [15:0]      screen_store [SCREEN_ROWS][SCREEN_COLS];
   logic [ROW_W-1:0] cursor_row_now;
   logic [COL_W-1:0] cursor_col_now;
   logic [3:0]       background_now;
   logic [3:0]       foreground_now;

   // responses still owed by the block, oldest first
   response_type  owed_responses [$];

   idle_mode_type idle_mode = IDLE_NONE;
   int            hold_off_cycles = 0;
   int            error_count = 0;
   int            cycle_count = 0;

   // directed table: reset contents, out of range reads, the unused action,
   // control characters at their limits, wrap, scroll, clear
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      // store reads back zero after reset
      '{'{ACT_READ, 8'h00, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd24, 7'd79}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      // reads outside the screen, all field bits set, and just past the edges
      '{'{ACT_READ, 8'hff, 5'd31, 7'd127}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd25, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd0, 7'd80}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      // unused action does nothing
      '{'{ACT_UNUSED, 8'hff, 5'd31, 7'd127}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      // plain put with reset colors, then read it back
      '{'{ACT_PUT, 8'h41, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd1, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd1, 8'h41, 8'h0f}},
      // backspace, then backspace clamped at column zero
      '{'{ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{'{ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{'{ACT_PUT, CH_TAB, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd4, 8'h00, 8'h00}},
      // character code extremes
      '{'{ACT_PUT, 8'hff, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd5, 8'h00, 8'h00}},
      '{'{ACT_PUT, 8'h00, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd6, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd0, 7'd4}, 8'd1, 1'b1, '{5'd0, 7'd6, 8'hff, 8'h0f}},
      '{'{ACT_PUT, CH_NEWLINE, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00}},
      // tabs run the column into saturation at one past the last column
      '{'{ACT_PUT, CH_TAB, 5'd0, 7'd0}, 8'd21, 1'b0, NO_RSP},
      '{'{ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd1, 7'd79, 8'h00, 8'h00}},
      '{'{ACT_PUT, CH_TAB, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd1, 7'd80, 8'h00, 8'h00}},
      // pending wrap taken by the next printable character
      '{'{ACT_PUT, 8'h42, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd2, 7'd1, 8'h00, 8'h00}},
      // newlines saturate the row without scrolling
      '{'{ACT_PUT, CH_NEWLINE, 5'd0, 7'd0}, 8'd30, 1'b0, NO_RSP},
      // printable character with a scroll pending
      '{'{ACT_PUT, 8'h43, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd24, 7'd1, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd24, 7'd1}, 8'd1, 1'b1, '{5'd24, 7'd1, 8'h20, 8'h0f}},
      '{'{ACT_READ, 8'h00, 5'd1, 7'd0}, 8'd1, 1'b0, NO_RSP},
      '{'{ACT_CLEAR, 8'h00, 5'd0, 7'd0}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
      '{'{ACT_READ, 8'h00, 5'd12, 7'd40}, 8'd1, 1'b1, '{5'd0, 7'd0, 8'h20, 8'h0f}},
      // a long line of text, wrapping past the right edge
      '{'{ACT_PUT, 8'h7e, 5'd0, 7'd0}, 8'd170, 1'b0, NO_RSP}
   };

   text_console_writer_unit #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .SCREEN_COLS (SCREEN_COLS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // console predictor: applies one request to the shadow state and returns
   // the response the block owes for it
   function automatic response_type apply_console_request(request_type r);
      response_type rsp;
      logic [7:0]   attr;
      logic [15:0]  cell_word;
      rsp  = '0;
      attr = {background_now, foreground_now};
      case (r.action)
         ACT_PUT: begin
            if (r.char_code == CH_NEWLINE) begin
               if (cursor_row_now < SCREEN_ROWS) cursor_row_now++;
               cursor_col_now = '0;
            end else if (r.char_code == CH_TAB) begin
               if (int'(cursor_col_now) + TAB_STEP > SCREEN_COLS)
                  cursor_col_now = COL_W'(SCREEN_COLS);
               else
                  cursor_col_now = cursor_col_now + COL_W'(TAB_STEP);
            end else if (r.char_code == CH_BACKSPACE) begin
               if (cursor_col_now > 0) cursor_col_now--;
            end else begin
               // wrap first, then scroll if the row fell off the bottom
               if (cursor_col_now >= SCREEN_COLS) begin
                  cursor_col_now = '0;
                  if (cursor_row_now < SCREEN_ROWS) cursor_row_now++;
               end
               if (cursor_row_now >= SCREEN_ROWS) begin
                  for (int rr = 0; rr < SCREEN_ROWS - 1; rr++)
                     for (int cc = 0; cc < SCREEN_COLS; cc++)
                        screen_store[rr][cc] = screen_store[rr+1][cc];
                  for (int cc = 0; cc < SCREEN_COLS; cc++)
                     screen_store[SCREEN_ROWS-1][cc] = {attr, CH_BLANK};
                  cursor_row_now = ROW_W'(SCREEN_ROWS - 1);
               end
               screen_store[cursor_row_now][cursor_col_now] = {attr, r.char_code};
               cursor_col_now++;
            end
         end
         ACT_CLEAR: begin
            for (int rr = 0; rr < SCREEN_ROWS; rr++)
               for (int cc = 0; cc < SCREEN_COLS; cc++)
                  screen_store[rr][cc] = {attr, CH_BLANK};
            cursor_row_now = '0;
            cursor_col_now = '0;
         end
         ACT_READ: begin
            // out of range reads report zero
            if (r.read_row < SCREEN_ROWS && r.read_col < SCREEN_COLS) begin
               cell_word     = screen_store[r.read_row][r.read_col];
               rsp.cell_char = cell_word[7:0];
               rsp.cell_attr = cell_word[15:8];
            end
         end
         default: ;
      endcase
      rsp.cursor_row = cursor_row_now;
      rsp.cursor_col = cursor_col_now;
      return rsp;
   endfunction

   // random console traffic: mostly text with line breaks so that the cursor
   // keeps reaching the bottom and scrolling, reads of screen cells, rare clears
   function automatic request_type random_request();
      request_type r;
      int          pick;
      pick        = $urandom_range(0, 999);
      r.action    = ACT_PUT;
      r.char_code = 8'($urandom_range(0, 255));
      r.read_row  = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
      r.read_col  = COL_W'($urandom_range(0, (1 << COL_W) - 1));
      if (pick < 4) begin
         r.action = ACT_CLEAR;
      end else if (pick < 10) begin
         r.action = ACT_UNUSED;
      end else if (pick < 210) begin
         r.action = ACT_READ;
         // most reads hit the screen, many on the cursor row; a few use any bits
         if ($urandom_range(0, 6) != 0) begin
            r.read_row = ($urandom_range(0, 1) == 0) ? cursor_row_now :
                         ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
            r.read_col = COL_W'($urandom_range(0, SCREEN_COLS - 1));
         end
      end else if (pick < 360) begin
         r.char_code = CH_NEWLINE;
      end else if (pick < 420) begin
         r.char_code = CH_TAB;
      end else if (pick < 480) begin
         r.char_code = CH_BACKSPACE;
      end
      return r;
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 68;
         IDLE_BOTH:   return $urandom_range(0, 99) < 15;
         default:     return 1'b0;
      endcase
   endfunction

   // offer one request from the falling edge on, hold it until accepted, and
   // record the response it is owed; valid stays high into a back-to-back request
   task automatic send_request(request_type r, logic typed, response_type want);
      response_type predicted;
      @(negedge clock);
      while (sender_idles()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.action;
      req_tdata  = REQ_W'({r.read_col, r.read_row, r.char_code});
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_console_request(r);
      owed_responses.push_back(typed ? want : predicted);
   endtask

   task automatic write_color(logic reg_index, logic [3:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = reg_index;
      csr_wdata = value;
      @(posedge clock);
      if (reg_index == REG_BACKGROUND) background_now = value;
      else foreground_now = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait until every owed response has come back
   task automatic wait_for_drain();
      while (owed_responses.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      request_type r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = REG_BACKGROUND;
      csr_wdata  = '0;

      // shadow state after reset: zero store, home cursor, white on black
      for (int rr = 0; rr < SCREEN_ROWS; rr++)
         for (int cc = 0; cc < SCREEN_COLS; cc++)
            screen_store[rr][cc] = '0;
      cursor_row_now = '0;
      cursor_col_now = '0;
      background_now = 4'h0;
      foreground_now = 4'hf;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; the block clears its store first with req_tready low
      foreach (directed_table[i])
         for (int k = 0; k < directed_table[i].repeat_count; k++)
            send_request(directed_table[i].req, directed_table[i].typed,
                         directed_table[i].want);

      // random phases, one per idling pattern, each with its own colors
      for (int phase = 0; phase < 4; phase++) begin
         // drop valid before the block comes back to idle
         @(negedge clock);
         req_tvalid = 1'b0;
         wait_for_drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            0: begin
               write_color(REG_BACKGROUND, 4'hf);
               write_color(REG_FOREGROUND, 4'h0);
            end
            1: begin
               write_color(REG_BACKGROUND, 4'h0);
               write_color(REG_FOREGROUND, 4'h0);
            end
            2: begin
               write_color(REG_BACKGROUND, 4'hf);
               write_color(REG_FOREGROUND, 4'hf);
            end
            default: begin
               write_color(REG_BACKGROUND, 4'($urandom_range(1, 14)));
               write_color(REG_FOREGROUND, 4'($urandom_range(1, 14)));
            end
         endcase
         idle_mode = idle_mode_type'(phase);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = random_request();
            send_request(r, 1'b0, NO_RSP);
            if (phase == 0 && n == 150) begin
               // receiver holds off while requests keep coming, so the block backs up
               hold_off_cycles = HOLD_OFF_CYCLES;
            end
            if (phase == 0 && n == 320) begin
               // sender pauses until the block has answered everything
               @(negedge clock);
               req_tvalid = 1'b0;
               wait_for_drain();
            end
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // response side: ready pattern per idle mode, long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_off_cycles--;
         end else begin
            case (idle_mode)
               IDLE_RECEIVER: rsp_tready = $urandom_range(0, 99) >= 68;
               IDLE_BOTH:     rsp_tready = $urandom_range(0, 99) >= 15;
               default:       rsp_tready = 1'b1;
            endcase
         end
      end
   end

   // response checker: compare each accepted response with the oldest one owed
   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         // tdata carries the cursor row in the lowest bits
         got.cursor_row = rsp_tdata[ROW_W-1:0];
         got.cursor_col = rsp_tdata[ROW_W +: COL_W];
         got.cell_char  = rsp_tdata[ROW_W+COL_W +: 8];
         got.cell_attr  = rsp_tdata[ROW_W+COL_W+8 +: 8];
         if (owed_responses.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response: row %0d col %0d char %h attr %h",
                        got.cursor_row, got.cursor_col, got.cell_char, got.cell_attr);
         end else begin
            want = owed_responses.pop_front();
            if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
                got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: want %0d/%0d %h %h, got %0d/%0d %h %h",
                           want.cursor_row, want.cursor_col, want.cell_char,
                           want.cell_attr, got.cursor_row, got.cursor_col,
                           got.cell_char, got.cell_attr);
            end
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_cursor.sv
rtl/core/text_console_writer_unit.sv
tb/sv/tb_top.sv
